@@ design/tfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants for the telemetry frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

   localparam int NUM_WORDS = 8;

   localparam logic [7:0] START_BYTE = 8'hAB;
   localparam logic [7:0] STOP_HEAD  = 8'hAA;
   localparam logic [7:0] STOP_B1    = 8'h24;
   localparam logic [7:0] STOP_B2    = 8'hCE;
   localparam logic [7:0] STOP_B3    = 8'h0D;
   localparam logic [7:0] STOP_B4    = 8'h0A;

   localparam logic [5:0] STOP_LAST  = 6'd4;
   localparam logic [5:0] DATA_FIRST = 6'd1;
   localparam logic [5:0] DATA_LAST  = 6'd32;
   localparam logic [5:0] CSUM_POS   = 6'd33;
   localparam logic [5:0] FRAME_LAST = 6'd35;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_STOP  = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_FRAME = 1'b0,
      KIND_STOP  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic [NUM_WORDS-1:0][31:0]     words;
      logic [7:0]                     csum;
      logic                           csum_ok;
   } result_type;

   function automatic logic stop_tail_match(input logic [5:0] idx, input logic [7:0] b);
      logic hit;
      case (idx)
         6'd1:    hit = (b == STOP_B1);
         6'd2:    hit = (b == STOP_B2);
         6'd3:    hit = (b == STOP_B3);
         6'd4:    hit = (b == STOP_B4);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

`default_nettype wire

@@ design/tfd_parser.sv @@
// ----------------------------------------------------------------------------
// tfd_parser
// Byte-level hunt, stop-command match and frame assembly state.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_fire,
   input  wire logic [7:0]           byte_in,
   output logic                      emit,
   output tfd_pkg::result_type       result
);

   tfd_pkg::phase_type                       phase_ff, phase_in;
   logic [5:0]                               count_ff, count_in;
   logic [7:0]                               sum_ff, sum_in;
   logic [7:0]                               csum_ff, csum_in;
   logic [tfd_pkg::NUM_WORDS-1:0][31:0]      words_ff, words_in;

   logic       do_hunt;
   logic [5:0] idx_m1;
   logic [2:0] widx;
   logic [7:0] calc;

   assign idx_m1 = count_ff - 6'd1;
   assign widx   = idx_m1[4:2];
   assign calc   = 8'd0 - sum_ff;

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      csum_in        = csum_ff;
      words_in       = words_ff;
      do_hunt        = 1'b0;
      emit           = 1'b0;
      result         = '0;
      result.kind    = tfd_pkg::KIND_FRAME;
      case (phase_ff)
         tfd_pkg::PH_STOP: begin
            if (tfd_pkg::stop_tail_match(count_ff, byte_in)) begin
               if (count_ff == tfd_pkg::STOP_LAST) begin
                  phase_in    = tfd_pkg::PH_HUNT;
                  count_in    = 6'd0;
                  emit        = 1'b1;
                  result.kind = tfd_pkg::KIND_STOP;
               end else begin
                  count_in = count_ff + 6'd1;
               end
            end else begin
               do_hunt = 1'b1;
            end
         end
         tfd_pkg::PH_FRAME: begin
            if (count_ff >= tfd_pkg::DATA_FIRST && count_ff <= tfd_pkg::DATA_LAST) begin
               words_in[widx] = {words_ff[widx][23:0], byte_in};
               sum_in         = sum_ff + byte_in;
            end else if (count_ff == tfd_pkg::CSUM_POS) begin
               csum_in = byte_in;
            end
            if (count_ff >= tfd_pkg::FRAME_LAST) begin
               phase_in       = tfd_pkg::PH_HUNT;
               count_in       = 6'd0;
               emit           = 1'b1;
               result.words   = words_ff;
               result.csum    = csum_ff;
               result.csum_ok = (calc == csum_ff);
            end else begin
               count_in = count_ff + 6'd1;
            end
         end
         default: begin
            do_hunt = 1'b1;
         end
      endcase
      if (do_hunt) begin
         if (byte_in == tfd_pkg::START_BYTE) begin
            phase_in = tfd_pkg::PH_FRAME;
            count_in = 6'd1;
            sum_in   = byte_in;
         end else if (byte_in == tfd_pkg::STOP_HEAD) begin
            phase_in = tfd_pkg::PH_STOP;
            count_in = 6'd1;
         end else begin
            phase_in = tfd_pkg::PH_HUNT;
            count_in = 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tfd_pkg::PH_HUNT;
         count_ff <= 6'd0;
         sum_ff   <= 8'd0;
         csum_ff  <= 8'd0;
      end else if (byte_fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         csum_ff  <= csum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_fire) begin
         words_ff <= words_in;
      end
   end

   a_stop_count : assert property (@(posedge clock) disable iff (reset)
      phase_ff == tfd_pkg::PH_STOP |-> count_ff >= 6'd1 && count_ff <= tfd_pkg::STOP_LAST)
      else $error("stop match index out of range");

   a_frame_count : assert property (@(posedge clock) disable iff (reset)
      phase_ff == tfd_pkg::PH_FRAME |-> count_ff >= 6'd1 && count_ff <= tfd_pkg::FRAME_LAST)
      else $error("frame byte index out of range");

   a_hunt_count : assert property (@(posedge clock) disable iff (reset)
      phase_ff == tfd_pkg::PH_HUNT |-> count_ff == 6'd0)
      else $error("hunt phase with nonzero index");

   a_emit_hunt : assert property (@(posedge clock) disable iff (reset)
      byte_fire && emit |=> phase_ff == tfd_pkg::PH_HUNT)
      else $error("phase not back to hunt after a result");

endmodule

`default_nettype wire

@@ design/tfd_out_reg.sv @@
// ----------------------------------------------------------------------------
// tfd_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire tfd_pkg::result_type  result_in,
   output logic                      space,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output tfd_pkg::result_type       out_data
);

   logic                 valid_ff;
   tfd_pkg::result_type  data_ff;

   assign space     = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

@@ design/telemetry_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_deframer
// Serial byte deframer for telemetry frames and the stop command.
//
// req_* carries one received byte per word. Bytes are dropped until a start
// byte 0xAB opens a 36-byte telemetry frame or 0xAA opens the stop command
// AA 24 CE 0D 0A. A completed frame yields one rsp word with the eight raw
// float words, the received checksum and a checksum match flag (tuser 0);
// a completed stop command yields one rsp word of all-zero data (tuser 1).
// A byte that breaks a stop command is rescanned as a hunt byte.
// Throughput is one byte per cycle; the byte state updates in the accept
// cycle and the result appears in the output register in the cycle after
// the final byte is accepted. req_tready drops only while a result is held
// and rsp_tready is low; bytes are then held off until the result is taken.
// Reset returns to hunting and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_deframer (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // byte_in[7:0]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [271:0]       rsp_tdata,   // altitude_bits, pressure_bits, accel_x_bits,
                                           // accel_y_bits, accel_z_bits, angle_x_bits,
                                           // angle_y_bits, angle_z_bits, received_checksum,
                                           // checksum_ok, zero fill
   output logic               rsp_tuser    // frame_kind
);

   logic                 byte_fire;
   logic                 emit;
   logic                 space;
   tfd_pkg::result_type  result;
   tfd_pkg::result_type  out_data;

   assign req_tready = space;
   assign byte_fire  = req_tvalid && space;

   tfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .byte_in   (req_tdata),
      .emit      (emit),
      .result    (result)
   );

   tfd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (byte_fire && emit),
      .result_in (result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {7'd0, out_data.csum_ok, out_data.csum, out_data.words};
   assign rsp_tuser = out_data.kind;

endmodule

`default_nettype wire
